// ===== hw/rtl/lcd_number_field_formatter_unit_macros.svh =====
// assertion helpers for the number field formatter
`ifndef LCD_NUMBER_FIELD_FORMATTER_UNIT_MACROS_SVH
`define LCD_NUMBER_FIELD_FORMATTER_UNIT_MACROS_SVH

// property that must hold in the same cycle
`define LNFF_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lnff check failed");

// property that must hold in the next cycle
`define LNFF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lnff check failed");

`endif

// ===== hw/rtl/lnff_pkg.sv =====
package lnff_pkg;

    localparam int unsigned BCD_DIGITS = 10;
    localparam int unsigned BCD_W      = 4 * BCD_DIGITS;
    localparam int unsigned WORD_W     = 32;
    localparam int unsigned PIPE_STG   = 4;

    localparam logic [7:0] CMD_ROW1   = 8'h80;
    localparam logic [7:0] CMD_ROW2   = 8'hC0;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_HEX_OFF = 8'h37;

    typedef struct packed {
        logic [7:0]        cmd;
        logic [3:0]        cnt;
        logic              hex;
        logic [WORD_W-1:0] value;
        logic [WORD_W-1:0] sh;
        logic [BCD_W-1:0]  bcd;
    } t_item;

endpackage

// ===== hw/rtl/lnff_bcd_pipe.sv =====
module lnff_bcd_pipe #(
    parameter int VALUE_BITS = 32,
    parameter int MAX_DIGITS = 10
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [4:0]       i_column,
    input  logic [1:0]       i_row,
    input  logic [31:0]      i_value,
    input  logic [3:0]       i_digit_count,
    input  logic             i_opcode,
    output logic             o_valid,
    output lnff_pkg::t_item  o_item
);
    import lnff_pkg::*;

    localparam int STEPS   = (VALUE_BITS + PIPE_STG - 1) / PIPE_STG;
    localparam int HEX_LIM = (MAX_DIGITS < 8) ? MAX_DIGITS : 8;
    localparam logic [3:0] DEC_MAX = 4'(MAX_DIGITS);
    localparam logic [3:0] HEX_MAX = 4'(HEX_LIM);
    localparam logic [WORD_W-1:0] VMASK =
        (VALUE_BITS >= WORD_W) ? {WORD_W{1'b1}} : WORD_W'((64'd1 << VALUE_BITS) - 64'd1);

    // one double-dabble step: correct digits, shift in next value bit
    function automatic t_item dd_step(input t_item it);
        t_item r;
        r = it;
        for (int d = 0; d < BCD_DIGITS; d++) begin
            if (r.bcd[4*d +: 4] >= 4'd5) begin
                r.bcd[4*d +: 4] = r.bcd[4*d +: 4] + 4'd3;
            end
        end
        r.bcd = {r.bcd[BCD_W-2:0], r.sh[WORD_W-1]};
        r.sh  = {r.sh[WORD_W-2:0], 1'b0};
        return r;
    endfunction

    t_item r_stg [0:PIPE_STG];
    logic  r_vld [0:PIPE_STG];
    t_item n_in;
    logic [3:0] lim;
    logic [WORD_W-1:0] vm;

    always_comb begin
        vm = i_value & VMASK;
        lim = i_opcode ? HEX_MAX : DEC_MAX;
        n_in.cmd   = ((i_row == 2'd1) ? CMD_ROW1 : CMD_ROW2) + {3'b000, i_column} + 8'hFF;
        n_in.cnt   = (i_digit_count > lim) ? lim : i_digit_count;
        n_in.hex   = i_opcode;
        n_in.value = vm;
        n_in.sh    = vm << (WORD_W - VALUE_BITS);
        n_in.bcd   = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
        end
        if (i_en) begin
            r_stg[0] <= n_in;
        end
    end

    for (genvar s = 1; s <= PIPE_STG; s++) begin : g_stg
        t_item n_stg;
        always_comb begin
            n_stg = r_stg[s-1];
            for (int j = 0; j < STEPS; j++) begin
                if ((s - 1) * STEPS + j < VALUE_BITS) begin
                    n_stg = dd_step(n_stg);
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s] <= r_vld[s-1];
            end
            if (i_en) begin
                r_stg[s] <= n_stg;
            end
        end
    end

    assign o_valid = r_vld[PIPE_STG];
    assign o_item  = r_stg[PIPE_STG];

endmodule

// ===== hw/rtl/lcd_number_field_formatter_unit.sv =====
// channel   direction  beat                                        handshake
// request   in         column, row, value, digit_count, opcode     i_valid / o_stall
// result    out        is_char, out_byte, last                     o_valid / i_stall
//
// a request spends five register stages in the binary to bcd pipeline, then the
// byte serializer sends 1 + digit_count beats (capped at MAX_DIGITS, 8 in hex), one
// per cycle while i_stall is low, and takes the next request after its last beat
// reset clears all valid bits and the serializer; payload registers are not reset
// the pipeline moves only as a whole, so a stall holds every stage in place
module lcd_number_field_formatter_unit #(
    parameter int VALUE_BITS = 32,
    parameter int MAX_DIGITS = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [4:0]  i_column,
    input  logic [1:0]  i_row,
    input  logic [31:0] i_value,
    input  logic [3:0]  i_digit_count,
    input  logic        i_opcode,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_is_char,
    output logic [7:0]  o_out_byte,
    output logic        o_last
);
    import lnff_pkg::*;

    logic  pipe_valid;
    t_item pipe_item;
    logic  pipe_en;

    t_item r_it;
    logic  r_busy;
    logic  r_cmd_sent;
    logic  r_shown;
    logic [3:0] r_k;

    logic out_free;
    logic [3:0] dig;
    logic [7:0] ch;
    logic       nz;

    assign out_free = !o_valid || !i_stall;
    assign pipe_en  = !pipe_valid || !r_busy;
    assign o_stall  = !pipe_en;

    lnff_bcd_pipe #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_pipe (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (pipe_en),
        .i_valid       (i_valid),
        .i_column      (i_column),
        .i_row         (i_row),
        .i_value       (i_value),
        .i_digit_count (i_digit_count),
        .i_opcode      (i_opcode),
        .o_valid       (pipe_valid),
        .o_item        (pipe_item)
    );

    always_comb begin
        if (r_it.hex) begin
            dig = 4'(r_it.value >> {r_k[2:0], 2'b00});
            ch  = (dig <= 4'd9) ? (CH_ZERO + {4'b0000, dig}) : (CH_HEX_OFF + {4'b0000, dig});
            nz  = 1'b1;
        end else begin
            dig = 4'(r_it.bcd >> {r_k, 2'b00});
            nz  = (dig != 4'd0) || r_shown || (r_k == 4'd0);
            ch  = nz ? (CH_ZERO + {4'b0000, dig}) : CH_SPACE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_cmd_sent <= 1'b0;
            r_shown    <= 1'b0;
            o_valid    <= 1'b0;
        end else begin
            if (!r_busy) begin
                if (pipe_valid) begin
                    r_busy     <= 1'b1;
                    r_cmd_sent <= 1'b0;
                    r_shown    <= 1'b0;
                end
                if (out_free) begin
                    o_valid <= 1'b0;
                end
            end else if (out_free) begin
                o_valid <= 1'b1;
                if (!r_cmd_sent) begin
                    r_cmd_sent <= 1'b1;
                    if (r_it.cnt == 4'd0) begin
                        r_busy <= 1'b0;
                    end
                end else begin
                    if (dig != 4'd0) begin
                        r_shown <= 1'b1;
                    end
                    if (r_k == 4'd0) begin
                        r_busy <= 1'b0;
                    end
                end
            end
        end
    end

    // payload side of the serializer
    always_ff @(posedge i_clk) begin
        if (!r_busy && pipe_valid) begin
            r_it <= pipe_item;
        end
        if (r_busy && out_free) begin
            if (!r_cmd_sent) begin
                o_is_char  <= 1'b0;
                o_out_byte <= r_it.cmd;
                o_last     <= (r_it.cnt == 4'd0);
                r_k        <= r_it.cnt - 4'd1;
            end else begin
                o_is_char  <= 1'b1;
                o_out_byte <= ch;
                o_last     <= (r_k == 4'd0);
                r_k        <= r_k - 4'd1;
            end
        end
    end

endmodule

// ===== hw/rtl/lnff_chk.sv =====
`include "lcd_number_field_formatter_unit_macros.svh"

module lnff_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input logic       o_is_char,
    input logic [7:0] o_out_byte,
    input logic       o_last
);

    // space, digit or upper-case hex letter
    logic glyph;
    assign glyph = (o_out_byte == 8'h20) ||
                   ((o_out_byte >= 8'h30) && (o_out_byte <= 8'h39)) ||
                   ((o_out_byte >= 8'h41) && (o_out_byte <= 8'h46));

    `LNFF_ASSERT_NEXT(a_hold, o_valid && i_stall, o_valid && $stable(o_out_byte))
    `LNFF_ASSERT_NEXT(a_burst, o_valid && !i_stall && !o_last, o_valid && o_is_char)
    `LNFF_ASSERT_NOW(a_charset, o_valid && o_is_char, glyph)

endmodule

bind lcd_number_field_formatter_unit lnff_chk u_lnff_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_valid    (o_valid),
    .i_stall    (i_stall),
    .o_is_char  (o_is_char),
    .o_out_byte (o_out_byte),
    .o_last     (o_last)
);

// ===== sim/tb_lcd_number_field_formatter_unit.sv =====
module tb_lcd_number_field_formatter_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic OP_DEC = 1'b0;
    localparam logic OP_HEX = 1'b1;
    localparam int WATCHDOG_CYCLES = 4000;
    localparam int DIRECTED_ROWS = 20;
    localparam int RANDOM_ITEMS = 390;
    localparam int CALM_ITEMS = 60;

    typedef struct packed {
        logic       is_char;
        logic [7:0] out_byte;
        logic       last;
    } field_byte_t;

    typedef struct {
        logic [4:0]  column;
        logic [1:0]  row;
        logic [31:0] value;
        logic [3:0]  digit_count;
        logic        opcode;
        int          n_typed;
        field_byte_t typed[3];
    } request_row_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [4:0]  i_column;
    logic [1:0]  i_row;
    logic [31:0] i_value;
    logic [3:0]  i_digit_count;
    logic        i_opcode;
    logic        o_valid;
    logic        i_stall;
    logic        o_is_char;
    logic [7:0]  o_out_byte;
    logic        o_last;

    field_byte_t  pending_bytes[$];
    request_row_t req_table[DIRECTED_ROWS];
    int           fail_count;
    int           byte_count;
    int           idle_cycles;
    bit           stimulus_done;
    bit           calm;

    lcd_number_field_formatter_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_column(i_column), .i_row(i_row), .i_value(i_value),
        .i_digit_count(i_digit_count), .i_opcode(i_opcode), .o_valid(o_valid),
        .i_stall(i_stall), .o_is_char(o_is_char), .o_out_byte(o_out_byte),
        .o_last(o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // cursor byte then the digits of the field, most significant first
    task automatic format_field(input logic [4:0] column, input logic [1:0] row,
                                input logic [31:0] value, input logic [3:0] count,
                                input logic opcode);
        logic [7:0]  cmd;
        int          width;
        int          k;
        logic [31:0] scaled;
        logic [3:0]  digit;
        logic [7:0]  ch;
        bit          shown;
        cmd = ((row == 2'd1) ? 8'h80 : 8'hC0) + {3'b0, column} - 8'd1;
        width = count;
        if (opcode == OP_HEX && width > 8) width = 8;
        if (width > 10) width = 10;
        pending_bytes.push_back('{1'b0, cmd, width == 0});
        shown = 1'b0;
        for (k = width - 1; k >= 0; k--) begin
            if (opcode == OP_HEX) begin
                digit = value[4*k +: 4];
                ch = (digit <= 9) ? 8'h30 + digit : 8'h37 + digit;
            end else begin
                scaled = value;
                for (int j = 0; j < k; j++) scaled = scaled / 10;
                digit = 4'(scaled % 10);
                if (digit != 0) shown = 1'b1;
                ch = (shown || k == 0) ? 8'h30 + digit : 8'h20;
            end
            pending_bytes.push_back('{1'b1, ch, k == 0});
        end
    endtask

    task automatic send_request(input request_row_t r);
        int base;
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        base = pending_bytes.size();
        format_field(r.column, r.row, r.value, r.digit_count, r.opcode);
        // typed rows must agree with the predictor too
        for (int t = 0; t < r.n_typed; t++)
            if (pending_bytes[base + t] !== r.typed[t]) begin
                $error("table row: expected %h predicted %h", r.typed[t],
                       pending_bytes[base + t]);
                fail_count++;
            end
        i_valid <= 1'b1;
        i_column <= r.column;
        i_row <= r.row;
        i_value <= r.value;
        i_digit_count <= r.digit_count;
        i_opcode <= r.opcode;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    function automatic request_row_t mk(input logic [4:0] c, input logic [1:0] r,
                                        input logic [31:0] v, input logic [3:0] n,
                                        input logic op);
        request_row_t q;
        q.column = c; q.row = r; q.value = v; q.digit_count = n; q.opcode = op;
        q.n_typed = 0;
        return q;
    endfunction

    initial begin
        request_row_t r;
        fail_count = 0;
        byte_count = 0;
        stimulus_done = 0;
        calm = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_column = '0;
        i_row = '0;
        i_value = '0;
        i_digit_count = '0;
        i_opcode = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        req_table[0] = mk(5'd1, 2'd1, 32'd0, 4'd1, OP_DEC);
        req_table[0].n_typed = 2;
        req_table[0].typed[0] = '{1'b0, 8'h80, 1'b0};
        req_table[0].typed[1] = '{1'b1, 8'h30, 1'b1};
        req_table[1] = mk(5'd16, 2'd2, 32'd0, 4'd0, OP_DEC);
        req_table[1].n_typed = 1;
        req_table[1].typed[0] = '{1'b0, 8'hCF, 1'b1};
        req_table[2] = mk(5'd0, 2'd1, 32'hF, 4'd1, OP_HEX);
        req_table[2].n_typed = 2;
        req_table[2].typed[0] = '{1'b0, 8'h7F, 1'b0};
        req_table[2].typed[1] = '{1'b1, 8'h46, 1'b1};
        req_table[3] = mk(5'd31, 2'd3, 32'hFFFF_FFFF, 4'd15, OP_DEC);
        req_table[4] = mk(5'd0, 2'd0, 32'hFFFF_FFFF, 4'd15, OP_HEX);
        req_table[5] = mk(5'd8, 2'd1, 32'd0, 4'd10, OP_DEC);
        req_table[6] = mk(5'd8, 2'd2, 32'd0, 4'd8, OP_HEX);
        req_table[7] = mk(5'd3, 2'd1, 32'd1234567890, 4'd10, OP_DEC);
        req_table[8] = mk(5'd3, 2'd2, 32'd1234567890, 4'd4, OP_DEC);
        req_table[9] = mk(5'd5, 2'd1, 32'h89AB_CDEF, 4'd9, OP_HEX);
        req_table[10] = mk(5'd5, 2'd3, 32'h0123_4567, 4'd8, OP_HEX);
        req_table[11] = mk(5'd12, 2'd0, 32'd1000, 4'd6, OP_DEC);
        req_table[12] = mk(5'd2, 2'd1, 32'd42, 4'd11, OP_DEC);
        req_table[13] = mk(5'd10, 2'd2, 32'hAAAA_5555, 4'd7, OP_HEX);
        req_table[14] = mk(5'd17, 2'd2, 32'h5555_AAAA, 4'd12, OP_DEC);
        req_table[15] = mk(5'd1, 2'd1, 32'd9, 4'd3, OP_DEC);
        req_table[16] = mk(5'd16, 2'd1, 32'd4294967295, 4'd10, OP_DEC);
        req_table[17] = mk(5'd4, 2'd1, 32'h0000_00A0, 4'd2, OP_HEX);
        req_table[18] = mk(5'd6, 2'd2, 32'd100000, 4'd5, OP_DEC);
        req_table[19] = mk(5'd9, 2'd1, 32'd7, 4'd0, OP_HEX);
        for (int i = 0; i < DIRECTED_ROWS; i++) send_request(req_table[i]);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            r = mk(5'($urandom_range(1, 16)), 2'($urandom_range(1, 2)), $urandom,
                   4'($urandom_range(1, 10)), 1'($urandom_range(0, 1)));
            if ($urandom_range(0, 7) == 0) begin
                r.column = 5'($urandom);
                r.row = 2'($urandom);
                r.digit_count = 4'($urandom);
            end
            case ($urandom_range(0, 3))
                0: r.value = $urandom_range(0, 999);
                1: r.value = $urandom & 32'h0000_FFFF;
                default: ;
            endcase
            if (i >= RANDOM_ITEMS - CALM_ITEMS) calm = 1;
            send_request(r);
        end
        i_valid <= 1'b0;
        stimulus_done = 1;
    end

    // result side: random stall bursts, check against the oldest expectation
    initial begin
        field_byte_t want;
        int burst;
        i_stall = 1'b0;
        burst = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                byte_count++;
                if (pending_bytes.size() == 0) begin
                    $error("beat with nothing expected: %h", o_out_byte);
                    fail_count++;
                end else begin
                    want = pending_bytes.pop_front();
                    if (o_is_char !== want.is_char) begin
                        $error("is_char expected %0d actual %0d", want.is_char, o_is_char);
                        fail_count++;
                    end
                    if (o_out_byte !== want.out_byte) begin
                        $error("out_byte expected %h actual %h", want.out_byte, o_out_byte);
                        fail_count++;
                    end
                    if (o_last !== want.last) begin
                        $error("last expected %0d actual %0d", want.last, o_last);
                        fail_count++;
                    end
                end
            end
            if (burst > 0) begin
                burst--;
                i_stall <= (burst > 0);
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                burst = $urandom_range(1, 16);
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles = 0;
            else idle_cycles++;
            if (stimulus_done && pending_bytes.size() == 0) begin
                repeat (40) @(posedge i_clk);
                $display("covered %0d requests and %0d result beats, dec and hex modes",
                         DIRECTED_ROWS + RANDOM_ITEMS, byte_count);
                if (fail_count == 0 && pending_bytes.size() == 0) begin
                    $display("PASS");
                end else begin
                    $display("FAIL");
                end
                $finish;
            end else if (idle_cycles >= WATCHDOG_CYCLES) begin
                $display("watchdog expired with %0d beats outstanding",
                         pending_bytes.size());
                $display("FAIL");
                $finish;
            end
        end
    end
endmodule
